// ===== src/rcm_pkg.sv =====
package rcm_pkg;

    localparam int TEX_SIZE_DEF = 64;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    localparam logic [1:0] KIND_CEILING = 2'd0;
    localparam logic [1:0] KIND_WALL    = 2'd1;
    localparam logic [1:0] KIND_DOOR    = 2'd2;
    localparam logic [1:0] KIND_FLOOR   = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CEILING_COLOUR = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FLOOR_COLOUR   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PLAYER_X       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PLAYER_Y       = 3'd5;

    localparam logic [11:0] SCREEN_WIDTH_RST  = 12'd640;
    localparam logic [11:0] SCREEN_HEIGHT_RST = 12'd480;

    typedef struct packed {
        logic        operation;
        logic [10:0] column;
        logic [10:0] wall_top;
        logic [11:0] wall_bottom;
        logic [15:0] line_height;
        logic [15:0] wall_frac;
        logic        hit_side;
        logic        ray_x_positive;
        logic        ray_y_negative;
        logic [7:0]  cell_x;
        logic [7:0]  cell_y;
        logic        is_door;
    } t_item;

    typedef struct packed {
        logic [21:0] screen_address;
        logic [1:0]  pixel_kind;
        logic [1:0]  texture_select;
        logic [11:0] texel_address;
        logic [23:0] fill_colour;
        logic        last_row;
    } t_result;

    typedef struct packed {
        logic        start;
        logic [15:0] line_height;
        logic [16:0] offset;
    } t_setup_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] step;
        logic [39:0] position;
    } t_setup_rsp;

endpackage

// ===== src/rcm_stream_if.sv =====
interface rcm_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/rcm_setup_unit.sv =====
module rcm_setup_unit #(
    parameter int TEX_SIZE = rcm_pkg::TEX_SIZE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rcm_pkg::t_setup_req i_req,
    output rcm_pkg::t_setup_rsp o_rsp
);

    localparam int LOG2_TEX  = $clog2(TEX_SIZE);
    localparam int DIV_STEPS = LOG2_TEX + 17;
    localparam int MUL_STEPS = 17;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;

    logic [1:0]       r_state;
    logic [CNT_W-1:0] r_count;
    logic [16:0]      r_rem;
    logic [31:0]      r_quo;
    logic [15:0]      r_div;
    logic [16:0]      r_mplier;
    logic [39:0]      r_mcand;
    logic [39:0]      r_acc;

    logic        w_bit;
    logic [16:0] w_shift;
    logic [39:0] w_a;
    logic [39:0] w_b;
    logic        w_sub;
    logic [40:0] w_sum;
    logic        w_ge;
    logic [31:0] n_quo;
    logic        w_last;

    // dividend is TEX_SIZE << 16: a single one at the top, zeros below
    assign w_bit   = (r_count == CNT_W'(DIV_STEPS - 1));
    assign w_shift = {r_rem[15:0], w_bit};
    assign w_last  = (r_count == '0);

    // shared add/subtract unit
    always_comb begin
        case (r_state)
            S_DIV: begin
                w_a   = {23'b0, w_shift};
                w_b   = {24'b0, r_div};
                w_sub = 1'b1;
            end
            default: begin
                w_a   = r_acc;
                w_b   = r_mcand;
                // sign bit of the offset carries negative weight
                w_sub = w_last;
            end
        endcase
    end

    assign w_sum = {1'b0, w_a} + (w_sub ? ~{1'b0, w_b} : {1'b0, w_b}) + {40'b0, w_sub};
    assign w_ge  = ~w_sum[40];
    assign n_quo = {r_quo[30:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_state <= S_DIV;
                        r_count <= CNT_W'(DIV_STEPS - 1);
                    end
                end
                S_DIV: begin
                    if (w_last) begin
                        r_state <= S_MUL;
                        r_count <= CNT_W'(MUL_STEPS - 1);
                    end else begin
                        r_count <= r_count - 1'b1;
                    end
                end
                S_MUL: begin
                    if (w_last) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_count <= r_count - 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    r_rem    <= '0;
                    r_quo    <= '0;
                    r_div    <= i_req.line_height;
                    r_mplier <= i_req.offset;
                end
            end
            S_DIV: begin
                r_rem <= w_ge ? w_sum[16:0] : w_shift;
                r_quo <= n_quo;
                if (w_last) begin
                    r_acc   <= '0;
                    r_mcand <= {8'b0, n_quo};
                end
            end
            S_MUL: begin
                if (r_mplier[0]) begin
                    r_acc <= w_sum[39:0];
                end
                r_mcand  <= {r_mcand[38:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[16:1]};
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    assign o_rsp.busy     = (r_state != S_IDLE);
    assign o_rsp.done     = (r_state == S_MUL) && w_last;
    assign o_rsp.step     = r_quo;
    // fold in the final partial product on the done cycle
    assign o_rsp.position = r_mplier[0] ? w_sum[39:0] : r_acc;

endmodule

// ===== src/raycast_column_texture_mapper.sv =====
// Textured wall column renderer for a grid raycaster.
// Input channel i_item carries two kinds of transaction: a begin item that
// loads one screen column (span, line height, hit fraction, side, ray signs,
// hit cell, door flag) and a pixel item that asks for the next row.
// Output channel o_result carries one result per emitted row: screen address,
// pixel kind, texture number, texel address, fill colour and last-row flag.
// Registers are written through i_cfg_we / i_cfg_index / i_cfg_data.
// A begin item gives no result and occupies the block while one shared
// 40-bit adder first runs a restoring division for the texture step, one
// quotient bit a cycle, then a shift-add multiply for the starting texture
// position, one offset bit a cycle. i_item.ready is low during that time.
// Pixel items are taken one per cycle; each result appears in the output
// register on the cycle after its transaction. A pixel with no active column
// or past the last row gives no result.
// When the receiver stalls, the result is held and a new item is taken only
// once the output register is free or is being emptied in the same cycle.
// Reset restores the register defaults and leaves no column loaded.
module raycast_column_texture_mapper #(
    parameter int TEX_SIZE = rcm_pkg::TEX_SIZE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    rcm_stream_if.sink                        i_item,
    rcm_stream_if.source                      o_result,
    input  logic                              i_cfg_we,
    input  logic [rcm_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [rcm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int LOG2_TEX = $clog2(TEX_SIZE);
    localparam int TXL_W    = (2 * LOG2_TEX > 12) ? 2 * LOG2_TEX : 12;

    rcm_pkg::t_item      w_item;
    rcm_pkg::t_result    r_out;
    rcm_pkg::t_setup_req w_req;
    rcm_pkg::t_setup_rsp w_rsp;

    logic [11:0] r_screen_width;
    logic [11:0] r_screen_height;
    logic [23:0] r_ceiling_colour;
    logic [23:0] r_floor_colour;
    logic [15:0] r_player_x;
    logic [15:0] r_player_y;

    logic [11:0]         r_row;
    logic                r_active;
    logic [10:0]         r_column;
    logic [10:0]         r_top;
    logic [11:0]         r_bottom;
    logic [LOG2_TEX-1:0] r_tex_col;
    logic [1:0]          r_tex_sel;
    logic                r_door;
    logic [31:0]         r_step;
    logic [39:0]         r_pos;
    logic                r_out_valid;

    logic                w_in_acc;
    logic                w_is_begin;
    logic                w_pix_acc;
    logic                w_out_free;
    logic                w_row_ok;
    logic                w_emit;
    logic [12:0]         w_row_next;
    logic [15:0]         w_lh_eff;
    logic [17:0]         w_offset;
    logic [LOG2_TEX-1:0] w_tx;
    logic                w_mirror;
    logic [1:0]          w_choice;
    logic [LOG2_TEX-1:0] w_ty;
    logic [TXL_W-1:0]    w_wall_wide;
    logic [TXL_W-1:0]    w_door_wide;
    logic [23:0]         w_addr_prod;
    logic [21:0]         w_addr;
    logic                w_above;
    logic                w_inside;

    assign w_item     = i_item.payload;
    assign w_in_acc   = i_item.valid && i_item.ready;
    assign w_is_begin = (w_item.operation == rcm_pkg::OP_BEGIN);
    assign w_pix_acc  = w_in_acc && !w_is_begin;
    assign w_out_free = !r_out_valid || o_result.ready;

    assign i_item.ready   = !w_rsp.busy && w_out_free;
    assign o_result.valid = r_out_valid;
    assign o_result.payload = r_out;

    // column setup
    assign w_lh_eff = (w_item.line_height == 16'd0) ? 16'd1 : w_item.line_height;
    assign w_offset = {7'b0, w_item.wall_top} - {7'b0, r_screen_height[11:1]}
                    + {3'b0, w_lh_eff[15:1]};
    assign w_mirror = w_item.hit_side ? w_item.ray_y_negative : w_item.ray_x_positive;
    assign w_tx     = w_item.wall_frac[15 -: LOG2_TEX];

    always_comb begin
        if (w_item.hit_side) begin
            w_choice = ({w_item.cell_y, 8'b0} < r_player_y) ? 2'd0 : 2'd1;
        end else begin
            w_choice = ({w_item.cell_x, 8'b0} < r_player_x) ? 2'd2 : 2'd3;
        end
    end

    assign w_req.start       = w_in_acc && w_is_begin;
    assign w_req.line_height = w_lh_eff;
    assign w_req.offset      = w_offset[16:0];

    rcm_setup_unit #(
        .TEX_SIZE (TEX_SIZE)
    ) u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // row generation
    assign w_row_ok    = r_active && (r_row < r_screen_height);
    assign w_emit      = w_pix_acc && w_row_ok;
    assign w_row_next  = {1'b0, r_row} + 13'd1;
    assign w_above     = (r_row < {1'b0, r_top});
    assign w_inside    = (r_row < r_bottom);
    assign w_ty        = r_pos[16 +: LOG2_TEX];
    assign w_wall_wide = TXL_W'({w_ty, r_tex_col});
    assign w_door_wide = TXL_W'({r_tex_col, w_ty});
    assign w_addr_prod = r_row * r_screen_width;
    assign w_addr      = w_addr_prod[21:0] + {11'b0, r_column};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width   <= rcm_pkg::SCREEN_WIDTH_RST;
            r_screen_height  <= rcm_pkg::SCREEN_HEIGHT_RST;
            r_ceiling_colour <= '0;
            r_floor_colour   <= '0;
            r_player_x       <= '0;
            r_player_y       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rcm_pkg::REG_SCREEN_WIDTH:   r_screen_width   <= i_cfg_data[11:0];
                rcm_pkg::REG_SCREEN_HEIGHT:  r_screen_height  <= i_cfg_data[11:0];
                rcm_pkg::REG_CEILING_COLOUR: r_ceiling_colour <= i_cfg_data;
                rcm_pkg::REG_FLOOR_COLOUR:   r_floor_colour   <= i_cfg_data;
                rcm_pkg::REG_PLAYER_X:       r_player_x       <= i_cfg_data[15:0];
                rcm_pkg::REG_PLAYER_Y:       r_player_y       <= i_cfg_data[15:0];
                default: begin
                    r_player_y <= r_player_y;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc && w_is_begin) begin
                r_active <= 1'b1;
                r_row    <= '0;
            end else if (w_pix_acc) begin
                if (!w_row_ok) begin
                    r_active <= 1'b0;
                end else begin
                    r_row <= w_row_next[11:0];
                    if (w_row_next >= {1'b0, r_screen_height}) begin
                        r_active <= 1'b0;
                    end
                end
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_is_begin) begin
            r_column  <= w_item.column;
            r_top     <= w_item.wall_top;
            r_bottom  <= w_item.wall_bottom;
            r_door    <= w_item.is_door;
            r_tex_col <= w_mirror ? ~w_tx : w_tx;
            r_tex_sel <= w_choice;
        end
        if (w_rsp.done) begin
            r_step <= w_rsp.step;
            r_pos  <= w_rsp.position;
        end else if (w_emit && !w_above && w_inside) begin
            r_pos <= r_pos + {8'b0, r_step};
        end
        if (w_emit) begin
            r_out.screen_address <= w_addr;
            r_out.last_row       <= (w_row_next == {1'b0, r_screen_height});
            if (w_above) begin
                r_out.pixel_kind     <= rcm_pkg::KIND_CEILING;
                r_out.texture_select <= 2'd0;
                r_out.texel_address  <= '0;
                r_out.fill_colour    <= r_ceiling_colour;
            end else if (w_inside) begin
                r_out.pixel_kind     <= r_door ? rcm_pkg::KIND_DOOR : rcm_pkg::KIND_WALL;
                r_out.texture_select <= r_tex_sel;
                r_out.texel_address  <= r_door ? w_door_wide[11:0] : w_wall_wide[11:0];
                r_out.fill_colour    <= '0;
            end else begin
                r_out.pixel_kind     <= rcm_pkg::KIND_FLOOR;
                r_out.texture_select <= 2'd0;
                r_out.texel_address  <= '0;
                r_out.fill_colour    <= r_floor_colour;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.busy |-> !i_item.ready)
        else $error("item taken while column setup runs");

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |=> w_rsp.busy)
        else $error("setup unit did not start");

    a_result_from_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_pix_acc))
        else $error("result without a pixel transaction");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int TEX_SIZE = rcm_pkg::TEX_SIZE_DEF;
    localparam int TEX_BITS = $clog2(TEX_SIZE);
    // a begin item keeps the block busy after its transaction while the column setup runs
    localparam int SETUP_SETTLE = 48;
    localparam longint CYCLE_LIMIT = 1000000;
    localparam int PHASE_COUNT = 12;
    localparam int PHASE_ITEMS = 90;
    localparam logic [rcm_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [rcm_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    class row_ledger;
        logic [11:0]         width_px, height_px;
        logic [23:0]         ceiling_rgb, floor_rgb;
        logic [15:0]         player_x, player_y;
        logic [11:0]         row_idx;
        logic [10:0]         column_q, top_q;
        logic [11:0]         bottom_q;
        logic [TEX_BITS-1:0] tex_col;
        logic [31:0]         step_q;
        logic [39:0]         tex_pos;
        logic [1:0]          tex_sel;
        logic                door_q, active_q;
        rcm_pkg::t_result    rows_due[$];
        int                  fails, items_in, rows_out;
        int                  kind_count[4];

        function new();
            width_px    = rcm_pkg::SCREEN_WIDTH_RST;
            height_px   = rcm_pkg::SCREEN_HEIGHT_RST;
            ceiling_rgb = '0;
            floor_rgb   = '0;
            player_x    = '0;
            player_y    = '0;
            row_idx     = '0;
            column_q    = '0;
            top_q       = '0;
            bottom_q    = '0;
            tex_col     = '0;
            step_q      = '0;
            tex_pos     = '0;
            tex_sel     = '0;
            door_q      = 1'b0;
            active_q    = 1'b0;
            fails       = 0;
            items_in    = 0;
            rows_out    = 0;
            foreach (kind_count[k]) kind_count[k] = 0;
        endfunction

        function void write_reg(logic [rcm_pkg::CFG_INDEX_W-1:0] idx,
                                logic [rcm_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                rcm_pkg::REG_SCREEN_WIDTH:   width_px    = data[11:0];
                rcm_pkg::REG_SCREEN_HEIGHT:  height_px   = data[11:0];
                rcm_pkg::REG_CEILING_COLOUR: ceiling_rgb = data[23:0];
                rcm_pkg::REG_FLOOR_COLOUR:   floor_rgb   = data[23:0];
                rcm_pkg::REG_PLAYER_X:       player_x    = data[15:0];
                rcm_pkg::REG_PLAYER_Y:       player_y    = data[15:0];
                default: ;
            endcase
        endfunction

        function void load_column(rcm_pkg::t_item it);
            logic [16:0] height;
            logic [31:0] frac_scaled;
            longint      offset;
            height   = (it.line_height == '0) ? 17'd1 : {1'b0, it.line_height};
            column_q = it.column;
            top_q    = it.wall_top;
            bottom_q = it.wall_bottom;
            door_q   = it.is_door;
            frac_scaled = {16'd0, it.wall_frac} * 32'(TEX_SIZE);
            tex_col = TEX_BITS'(frac_scaled >> 16);
            if ((!it.hit_side && it.ray_x_positive) || (it.hit_side && it.ray_y_negative))
                tex_col = TEX_BITS'(TEX_SIZE - 1) - tex_col;
            step_q = 32'((64'(TEX_SIZE) << 16) / height);
            offset = longint'(top_q) - longint'(height_px >> 1) + longint'(height >> 1);
            // wraps to 40 bits, two's complement when the top sits more than half a line height above the screen centre
            tex_pos = 40'(offset * longint'(step_q));
            if (it.hit_side)
                tex_sel = ({it.cell_y, 8'h00} < player_y) ? 2'd0 : 2'd1;
            else
                tex_sel = ({it.cell_x, 8'h00} < player_x) ? 2'd2 : 2'd3;
            row_idx  = '0;
            active_q = 1'b1;
        endfunction

        // returns 1 when the transaction is due to produce a row
        function bit advance(rcm_pkg::t_item it);
            rcm_pkg::t_result    r;
            logic [TEX_BITS-1:0] tex_row;
            items_in++;
            if (it.operation == rcm_pkg::OP_BEGIN) begin
                load_column(it);
                return 1'b0;
            end
            if (!active_q || row_idx >= height_px) begin
                active_q = 1'b0;
                return 1'b0;
            end
            r = '0;
            r.screen_address = 22'(int'(row_idx) * int'(width_px) + int'(column_q));
            if (row_idx < {1'b0, top_q}) begin
                r.pixel_kind  = rcm_pkg::KIND_CEILING;
                r.fill_colour = ceiling_rgb;
            end else if (row_idx < bottom_q) begin
                tex_row = tex_pos[16 +: TEX_BITS];
                tex_pos = tex_pos + 40'(step_q);
                r.texture_select = tex_sel;
                if (door_q) begin
                    r.pixel_kind    = rcm_pkg::KIND_DOOR;
                    r.texel_address = 12'(int'(tex_col) * TEX_SIZE + int'(tex_row));
                end else begin
                    r.pixel_kind    = rcm_pkg::KIND_WALL;
                    r.texel_address = 12'(int'(tex_row) * TEX_SIZE + int'(tex_col));
                end
            end else begin
                r.pixel_kind  = rcm_pkg::KIND_FLOOR;
                r.fill_colour = floor_rgb;
            end
            r.last_row = (int'(row_idx) + 1 == int'(height_px));
            row_idx = row_idx + 12'd1;
            if (row_idx >= height_px) active_q = 1'b0;
            rows_due.push_back(r);
            return 1'b1;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                fails++;
            end
        endfunction

        function void match_row(rcm_pkg::t_result got);
            rcm_pkg::t_result want;
            if (rows_due.size() == 0) begin
                $error("row at screen_address %0h with nothing expected", got.screen_address);
                fails++;
                return;
            end
            want = rows_due.pop_front();
            rows_out++;
            kind_count[want.pixel_kind]++;
            compare_field("screen_address", want.screen_address, got.screen_address);
            compare_field("pixel_kind", want.pixel_kind, got.pixel_kind);
            compare_field("texture_select", want.texture_select, got.texture_select);
            compare_field("texel_address", want.texel_address, got.texel_address);
            compare_field("fill_colour", want.fill_colour, got.fill_colour);
            compare_field("last_row", want.last_row, got.last_row);
        endfunction

        function int pending();
            return rows_due.size();
        endfunction

        function void close_out();
            if (rows_due.size() != 0) begin
                $error("%0d expected rows never arrived", rows_due.size());
                fails++;
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [rcm_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [rcm_pkg::CFG_DATA_W-1:0]  cfg_data;

    rcm_stream_if #(.t_payload(rcm_pkg::t_item))   item_if ();
    rcm_stream_if #(.t_payload(rcm_pkg::t_result)) res_if ();

    row_ledger ledger = new();
    bit        gaps_on;
    int        stall_left;
    int        stim_count = 0;
    int        settings_count = 0;
    longint    cycle_count = 0;

    raycast_column_texture_mapper uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_item      (item_if),
        .o_result    (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 70) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // result side: check on the handshake, then decide next cycle's ready
    initial begin
        res_if.ready = 1'b0;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready) ledger.match_row(res_if.payload);
            if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else begin
                res_if.ready <= 1'b1;
                if (gaps_on && $urandom_range(0, 5) == 0) stall_left = pick_gap();
            end
        end
    end

    function automatic rcm_pkg::t_item pixel_item();
        rcm_pkg::t_item it;
        logic [95:0]    raw;
        // junk in the other fields must be ignored
        raw = {$urandom, $urandom, $urandom};
        it = raw[$bits(rcm_pkg::t_item)-1:0];
        it.operation = rcm_pkg::OP_PIXEL;
        return it;
    endfunction

    function automatic rcm_pkg::t_item begin_item(logic [10:0] col, logic [10:0] top,
                                                  logic [11:0] bot, logic [15:0] lh,
                                                  logic [15:0] frac, logic side,
                                                  logic xpos, logic yneg,
                                                  logic [7:0] cx, logic [7:0] cy,
                                                  logic door);
        rcm_pkg::t_item it;
        it.operation      = rcm_pkg::OP_BEGIN;
        it.column         = col;
        it.wall_top       = top;
        it.wall_bottom    = bot;
        it.line_height    = lh;
        it.wall_frac      = frac;
        it.hit_side       = side;
        it.ray_x_positive = xpos;
        it.ray_y_negative = yneg;
        it.cell_x         = cx;
        it.cell_y         = cy;
        it.is_door        = door;
        return it;
    endfunction

    function automatic rcm_pkg::t_item random_begin();
        rcm_pkg::t_item it;
        logic [95:0]    raw;
        int             sh, top, bot, r;
        raw = {$urandom, $urandom, $urandom};
        it = raw[$bits(rcm_pkg::t_item)-1:0];
        it.operation = rcm_pkg::OP_BEGIN;
        sh = int'(ledger.height_px);
        r = $urandom_range(0, 99);
        if (r < 70) begin
            top = $urandom_range(0, (sh > 2047) ? 2047 : sh);
            bot = $urandom_range(top, (sh + 2 > 2048) ? 2048 : sh + 2);
            it.wall_top    = 11'(top);
            it.wall_bottom = 12'(bot);
            it.line_height = 16'(bot - top + $urandom_range(0, 40));
        end else if (r < 85) begin
            top = $urandom_range(0, 2047);
            it.wall_top    = 11'(top);
            it.wall_bottom = 12'($urandom_range(0, top));
        end
        r = $urandom_range(0, 19);
        if (r == 0) it.line_height = '0;
        else if (r == 1) it.line_height = '1;
        if ($urandom_range(0, 1) == 1) begin
            // put the hit cell next to the player so both texture choices show up
            it.cell_x = ledger.player_x[15:8] + 8'($urandom_range(0, 2)) - 8'd1;
            it.cell_y = ledger.player_y[15:8] + 8'($urandom_range(0, 2)) - 8'd1;
        end
        return it;
    endfunction

    task automatic send_item(input rcm_pkg::t_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_if.valid   <= 1'b1;
        item_if.payload <= it;
        do @(posedge clk); while (!item_if.ready);
        void'(ledger.advance(it));
        stim_count++;
    endtask

    task automatic drain();
        item_if.valid <= 1'b0;
        do @(posedge clk); while (ledger.pending() != 0);
    endtask

    task automatic write_reg(input logic [rcm_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [rcm_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        ledger.write_reg(idx, data);
    endtask

    task automatic apply_settings(input logic [11:0] sw, input logic [11:0] sh,
                                  input logic [23:0] ceil, input logic [23:0] flr,
                                  input logic [15:0] px, input logic [15:0] py);
        drain();
        repeat (SETUP_SETTLE) @(posedge clk);
        // upper data bits beyond each register are noise and must be dropped
        write_reg(rcm_pkg::REG_SCREEN_WIDTH, {12'($urandom), sw});
        write_reg(rcm_pkg::REG_SCREEN_HEIGHT, {12'($urandom), sh});
        write_reg(rcm_pkg::REG_CEILING_COLOUR, ceil);
        write_reg(rcm_pkg::REG_FLOOR_COLOUR, flr);
        write_reg(rcm_pkg::REG_PLAYER_X, {8'($urandom), px});
        write_reg(rcm_pkg::REG_PLAYER_Y, {8'($urandom), py});
        write_reg(REG_SPARE_LO, 24'($urandom));
        write_reg(REG_SPARE_HI, 24'($urandom));
        cfg_we <= 1'b0;
        settings_count++;
    endtask

    task automatic run_columns(input int quota);
        int stop_at, rows, sh;
        stop_at = stim_count + quota;
        while (stim_count < stop_at) begin
            if ($urandom_range(0, 39) == 0) drain();
            if ($urandom_range(0, 19) == 0) send_item(pixel_item());
            send_item(random_begin());
            sh = int'(ledger.height_px);
            if (sh > 64) rows = $urandom_range(1, 40);
            else if ($urandom_range(0, 6) == 0) rows = $urandom_range(0, sh);
            else rows = sh + $urandom_range(0, 2);
            repeat (rows) send_item(pixel_item());
        end
    endtask

    initial begin
        logic [11:0] sw, sh;
        logic [23:0] ceil, flr;
        logic [15:0] px, py;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        item_if.valid   = 1'b0;
        item_if.payload = '0;
        gaps_on         = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults: stray pixel, zero height, then restart mid-column
        send_item(pixel_item());
        send_item(begin_item(11'd0, 11'd0, 12'd2048, 16'd0, 16'd0,
                             1'b0, 1'b1, 1'b0, 8'hFF, 8'hFF, 1'b0));
        repeat (3) send_item(pixel_item());
        send_item(begin_item(11'd2047, 11'd2047, 12'd0, 16'hFFFF, 16'hFFFF,
                             1'b1, 1'b0, 1'b1, 8'h00, 8'h00, 1'b1));
        repeat (2) send_item(pixel_item());

        // four-row screen: door column, then a plain wall, each run past its end
        apply_settings(12'd1, 12'd4, 24'hFFFFFF, 24'h000000, 16'hFFFF, 16'h0000);
        send_item(begin_item(11'd5, 11'd1, 12'd3, 16'd2, 16'h8000,
                             1'b1, 1'b1, 1'b0, 8'h00, 8'h01, 1'b1));
        repeat (5) send_item(pixel_item());
        send_item(begin_item(11'd0, 11'd0, 12'd4, 16'd4, 16'h0001,
                             1'b0, 1'b0, 1'b1, 8'hFF, 8'h00, 1'b0));
        repeat (5) send_item(pixel_item());

        // zero screen height: nothing may come out
        apply_settings(12'd2048, 12'd0, 24'h000000, 24'hFFFFFF, 16'h0000, 16'hFFFF);
        send_item(begin_item(11'd2047, 11'd0, 12'd2048, 16'd100, 16'h1234,
                             1'b0, 1'b1, 1'b1, 8'h80, 8'h80, 1'b0));
        repeat (2) send_item(pixel_item());

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p % 4)
                0:       sw = 12'd1;
                1:       sw = 12'd2048;
                2:       sw = 12'hFFF;
                default: sw = 12'($urandom_range(1, 2048));
            endcase
            case (p)
                2:       sh = 12'd0;
                5:       sh = 12'd2048;
                7:       sh = 12'd1;
                9:       sh = 12'hFFF;
                default: sh = 12'($urandom_range(2, 40));
            endcase
            ceil = (p == 1) ? 24'hFFFFFF : 24'($urandom);
            flr  = (p == 1) ? 24'h000000 : ((p == 4) ? 24'hFFFFFF : 24'($urandom));
            px   = (p == 3) ? 16'hFFFF : ((p == 6) ? 16'h0000 : 16'($urandom));
            py   = (p == 3) ? 16'h0000 : ((p == 6) ? 16'hFFFF : 16'($urandom));
            gaps_on = (p % 4) != 3;
            apply_settings(sw, sh, ceil, flr, px, py);
            run_columns(PHASE_ITEMS);
        end

        drain();
        repeat (SETUP_SETTLE) @(posedge clk);
        ledger.close_out();
        $display("Run covered %0d transactions in and %0d rows out over %0d register settings",
                 ledger.items_in, ledger.rows_out, settings_count);
        $display("Rows by kind: ceiling %0d, wall %0d, door %0d, floor %0d",
                 ledger.kind_count[rcm_pkg::KIND_CEILING],
                 ledger.kind_count[rcm_pkg::KIND_WALL],
                 ledger.kind_count[rcm_pkg::KIND_DOOR],
                 ledger.kind_count[rcm_pkg::KIND_FLOOR]);
        if (ledger.fails == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
